[rtl/core/fedl_pkg.sv]
// Shared constants for the feedback echo delay line.
`timescale 1ns / 1ps
`default_nettype none
package fedl_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int GAIN_BITS      = 16;
   localparam int STEP_BITS      = $clog2(GAIN_BITS);
   localparam int DELAY_BITS     = 17;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;
   localparam int DEPTH_DEFAULT  = 65536;

   localparam logic [GAIN_BITS-1:0]  GAIN_ONE    = 16'h8000;
   localparam logic [DELAY_BITS-1:0] DELAY_RESET = 17'd1;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIX_GAIN     = 2'd1;

endpackage
`default_nettype wire

[rtl/core/feedback_echo_delay_line.sv]
// Feedback echo delay line: comb filter over a circular sample store.
// A sample transfer passes through a RAM read, a load, a bit-serial multiply
// over the gain bits, then sum and write-back with rsp_tvalid; the sum can wait
// for rsp_tready. A new sample is taken only in idle, after the last is written
// back; a clear transfer only resets the fill count. Synchronous active-high
// reset, no clearing pass: a fill count marks the store as empty after reset or a clear.
`timescale 1ns / 1ps
`default_nettype none
module feedback_echo_delay_line #(
   parameter int DEPTH = fedl_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [fedl_pkg::SAMPLE_BITS-1:0]    req_tdata,  // [23:0] sample_in
   input  wire logic [0:0]                          req_tuser,  // [0] op
   // result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [fedl_pkg::SAMPLE_BITS-1:0]    rsp_tdata,  // [23:0] sample_out
   output logic      [0:0]                          rsp_tuser,  // [0] clipped
   // configuration writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fedl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [fedl_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int SB     = fedl_pkg::SAMPLE_BITS;
   localparam int GB     = fedl_pkg::GAIN_BITS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DIST_W = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_SUM  = 5'b10000
   } state_type;

   state_type                           state_ff, state_in;
   logic [fedl_pkg::DELAY_BITS-1:0]     delay_length_ff, delay_length_in;
   logic [GB-1:0]                       mix_gain_ff, mix_gain_in;
   logic [ADDR_W-1:0]                   wr_ptr_ff, wr_ptr_in;
   logic [DIST_W-1:0]                   fill_ff, fill_in;
   logic [ADDR_W-1:0]                   rd_addr_ff, rd_addr_in;
   logic                                hit_ff, hit_in;
   logic [SB-1:0]                       sample_ff, sample_in;
   logic [GB-1:0]                       gain_sr_ff, gain_sr_in;
   logic [SB-1:0]                       delayed_ff, delayed_in;
   logic [SB-1:0]                       acc_hi_ff, acc_hi_in;
   logic [GB-1:0]                       acc_lo_ff, acc_lo_in;
   logic [fedl_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]                       rsp_data_ff, rsp_data_in;
   logic                                rsp_clip_ff, rsp_clip_in;

   logic                                req_xfer;
   logic [31:0]                         dl_wide;
   logic [DIST_W-1:0]                   delay_span;
   logic [DIST_W:0]                     wp_ext, span_ext, back;
   logic [SB:0]                         addend, mul_sum;
   logic [SB:0]                         prod15;
   logic [SB+1:0]                       sum_w;
   logic [SB-1:0]                       sat_val;
   logic                                sat_clip;
   logic                                retire;
   logic [SB-1:0]                       ram_rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // delay clamped to 1..DEPTH, then read address = write pointer - delay, wrapped
   always_comb begin
      dl_wide = 32'(delay_length_ff);
      if (dl_wide == 32'd0) begin
         delay_span = DIST_W'(1);
      end else if (dl_wide > 32'(DEPTH)) begin
         delay_span = DIST_W'(DEPTH);
      end else begin
         delay_span = DIST_W'(dl_wide);
      end
      wp_ext   = (DIST_W+1)'(wr_ptr_ff);
      span_ext = (DIST_W+1)'(delay_span);
      if (wp_ext >= span_ext) begin
         back = wp_ext - span_ext;
      end else begin
         back = wp_ext + (DIST_W+1)'(DEPTH) - span_ext;
      end
   end

   // one shift-add step per gain bit, LSB first; low bits fall into acc_lo
   assign addend  = gain_sr_ff[0] ? {delayed_ff[SB-1], delayed_ff} : '0;
   assign mul_sum = {acc_hi_ff[SB-1], acc_hi_ff} + addend;

   // product >>> 15 is the high word plus the top bit of the low word
   assign prod15 = {acc_hi_ff, acc_lo_ff[GB-1]};
   assign sum_w  = {{2{sample_ff[SB-1]}}, sample_ff} + {prod15[SB], prod15};

   always_comb begin
      sat_clip = !((sum_w[SB+1:SB-1] == 3'b000) || (sum_w[SB+1:SB-1] == 3'b111));
      if (!sat_clip) begin
         sat_val = sum_w[SB-1:0];
      end else if (sum_w[SB+1]) begin
         sat_val = {1'b1, {(SB-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(SB-1){1'b1}}};
      end
   end

   assign retire = (state_ff == ST_SUM) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in        = state_ff;
      delay_length_in = delay_length_ff;
      mix_gain_in     = mix_gain_ff;
      wr_ptr_in       = wr_ptr_ff;
      fill_in         = fill_ff;
      rd_addr_in      = rd_addr_ff;
      hit_in          = hit_ff;
      sample_in       = sample_ff;
      gain_sr_in      = gain_sr_ff;
      delayed_in      = delayed_ff;
      acc_hi_in       = acc_hi_ff;
      acc_lo_in       = acc_lo_ff;
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_clip_in     = rsp_clip_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fedl_pkg::CSR_DELAY_LENGTH: delay_length_in = csr_data[fedl_pkg::DELAY_BITS-1:0];
            fedl_pkg::CSR_MIX_GAIN:     mix_gain_in     = csr_data[GB-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser[0]) begin
                  // clear: forget every stored sample
                  fill_in = '0;
               end else begin
                  sample_in  = req_tdata;
                  rd_addr_in = back[ADDR_W-1:0];
                  hit_in     = (delay_span <= fill_ff);
                  gain_sr_in = (mix_gain_ff > fedl_pkg::GAIN_ONE) ? fedl_pkg::GAIN_ONE
                                                                  : mix_gain_ff;
                  state_in   = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            delayed_in = hit_ff ? ram_rd_data : '0;
            acc_hi_in  = '0;
            acc_lo_in  = '0;
            step_in    = '0;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            acc_hi_in  = mul_sum[SB:1];
            acc_lo_in  = {mul_sum[0], acc_lo_ff[GB-1:1]};
            gain_sr_in = gain_sr_ff >> 1;
            step_in    = step_ff + 1'b1;
            if (step_ff == fedl_pkg::STEP_BITS'(GB - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (retire) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_val;
               rsp_clip_in  = sat_clip;
               wr_ptr_in    = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
               if (fill_ff != DIST_W'(DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         delay_length_ff <= fedl_pkg::DELAY_RESET;
         mix_gain_ff     <= '0;
         wr_ptr_ff       <= '0;
         fill_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         delay_length_ff <= delay_length_in;
         mix_gain_ff     <= mix_gain_in;
         wr_ptr_ff       <= wr_ptr_in;
         fill_ff         <= fill_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      hit_ff      <= hit_in;
      sample_ff   <= sample_in;
      gain_sr_ff  <= gain_sr_in;
      delayed_ff  <= delayed_in;
      acc_hi_ff   <= acc_hi_in;
      acc_lo_ff   <= acc_lo_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   fedl_ram #(
      .WIDTH (SB),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (retire),
      .wr_addr (wr_ptr_ff),
      .wr_data (sat_val),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_clip_ff;

endmodule
`default_nettype wire

[rtl/core/fedl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fedl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
